>>> rtl/stree_pkg.sv
// Shared constants, types and codes for the segment tree range-sum block.
`timescale 1ns / 1ps
`default_nettype none
package stree_pkg;

   localparam int LEAVES = 1024;
   localparam int DEPTH  = 2 * LEAVES;
   localparam int IDX_W  = 10;
   localparam int DATA_W = 32;
   localparam int NODE_W = $clog2(DEPTH);
   localparam int PTR_W  = ((NODE_W > IDX_W + 1) ? NODE_W : IDX_W + 1) + 1;

   localparam logic OP_QUERY = 1'b0;
   localparam logic OP_SET   = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_QRY,
      ST_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      logic              we;
      logic [NODE_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [NODE_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] sum;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/stree_alu.sv
// Shared 32-bit add/subtract unit for node sums and range accumulation.
`timescale 1ns / 1ps
`default_nettype none
module stree_alu (
   input  stree_pkg::alu_op_type        op,
   input  logic [stree_pkg::DATA_W-1:0] a,
   input  logic [stree_pkg::DATA_W-1:0] b,
   output logic [stree_pkg::DATA_W-1:0] y
);
   import stree_pkg::*;

   always_comb begin
      case (op)
         ALU_SUB: y = a - b;
         default: y = a + b;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/stree_mem.sv
// Node-sum memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module stree_mem (
   input  logic                         clock,
   input  stree_pkg::mem_req_type       mem_req,
   output logic [stree_pkg::DATA_W-1:0] rd_data
);
   import stree_pkg::*;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/stree_ctrl.sv
// Sequencer for clearing, leaf updates and range-sum walks over the tree.
`timescale 1ns / 1ps
`default_nettype none
module stree_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [stree_pkg::IDX_W-1:0]  req_index,
   input  logic [stree_pkg::IDX_W-1:0]  req_right_end,
   input  logic [stree_pkg::DATA_W-1:0] req_value,
   output stree_pkg::mem_req_type       mem_req,
   input  logic [stree_pkg::DATA_W-1:0] rd_data,
   output stree_pkg::result_type        result,
   input  logic                         result_ready
);
   import stree_pkg::*;

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [NODE_W-1:0] node_ff, node_in;
   logic              first_ff, first_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] diff_ff, diff_in;
   logic [PTR_W-1:0]  a_ff, a_in;
   logic [PTR_W-1:0]  b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pend_ff, pend_in;

   alu_op_type        alu_op;
   logic [DATA_W-1:0] alu_a, alu_b, alu_y;

   logic              accept;
   logic              leaf_ok;
   logic [PTR_W-1:0]  lo_ext, hi_ext, hi_sat;
   logic              walk;
   logic [PTR_W-1:0]  b_dec;

   stree_alu u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

   assign accept  = req_valid && req_ready;
   assign lo_ext  = PTR_W'(req_index);
   assign hi_ext  = PTR_W'(req_right_end);
   assign leaf_ok = lo_ext < PTR_W'(LEAVES);
   assign hi_sat  = (hi_ext >= PTR_W'(LEAVES)) ? PTR_W'(LEAVES - 1) : hi_ext;
   assign walk    = a_ff < b_ff;
   assign b_dec   = b_ff - PTR_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == NODE_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_SET) begin
                  state_in = leaf_ok ? ST_UPD_RD : ST_IDLE;
               end else begin
                  state_in = ST_QRY;
               end
            end
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: begin
            state_in = (node_ff == NODE_W'(1)) ? ST_IDLE : ST_UPD_RD;
         end
         ST_QRY: begin
            if (!walk) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (result_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = 1'b0;
      mem_req.we    = 1'b0;
      mem_req.waddr = node_ff;
      mem_req.wdata = alu_y;
      mem_req.raddr = node_ff;
      alu_op        = ALU_ADD;
      alu_a         = acc_ff;
      alu_b         = rd_data;
      result.valid  = 1'b0;
      result.sum    = acc_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            mem_req.wdata = '0;
         end
         ST_IDLE: req_ready = 1'b1;
         ST_UPD_RD: mem_req.raddr = node_ff;
         ST_UPD_WR: begin
            mem_req.we = 1'b1;
            if (first_ff) begin
               alu_op        = ALU_SUB;
               alu_a         = val_ff;
               alu_b         = rd_data;
               mem_req.wdata = val_ff;
            end else begin
               alu_a = rd_data;
               alu_b = diff_ff;
            end
         end
         ST_QRY: begin
            if (a_ff[0]) begin
               mem_req.raddr = a_ff[NODE_W-1:0];
            end else begin
               mem_req.raddr = b_dec[NODE_W-1:0];
            end
         end
         ST_DONE: result.valid = 1'b1;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      clr_in   = clr_ff;
      node_in  = node_ff;
      first_in = first_ff;
      val_in   = val_ff;
      diff_in  = diff_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      pend_in  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: clr_in = clr_ff + NODE_W'(1);
         ST_IDLE: begin
            if (accept) begin
               node_in  = NODE_W'(lo_ext + PTR_W'(LEAVES));
               first_in = 1'b1;
               val_in   = req_value;
               a_in     = lo_ext + PTR_W'(LEAVES);
               b_in     = hi_sat + PTR_W'(LEAVES) + PTR_W'(1);
               acc_in   = '0;
            end
         end
         ST_UPD_WR: begin
            node_in  = node_ff >> 1;
            first_in = 1'b0;
            if (first_ff) begin
               diff_in = alu_y;
            end
         end
         ST_QRY: begin
            if (pend_ff) begin
               acc_in = alu_y;
            end
            if (walk) begin
               if (a_ff[0]) begin
                  a_in    = a_ff + PTR_W'(1);
                  pend_in = 1'b1;
               end else if (b_ff[0]) begin
                  b_in    = b_dec;
                  pend_in = 1'b1;
               end else begin
                  a_in = a_ff >> 1;
                  b_in = b_ff >> 1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
      node_ff  <= node_in;
      first_ff <= first_in;
      val_ff   <= val_in;
      diff_ff  <= diff_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
   end

`ifndef SYNTH
   a_walk_in_tree: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QRY && walk) |-> (b_ff <= PTR_W'(DEPTH)))
      else $error("range walk left the tree");

   a_done_flushed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> !pend_ff)
      else $error("result shown with a read still pending");

   a_node_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_RD || state_ff == ST_UPD_WR) |-> (node_ff != '0))
      else $error("update reached the unused node");

   a_update_to_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD_WR && state_in == ST_IDLE) |=> ($past(node_ff) == NODE_W'(1)))
      else $error("update finished below the root");
`endif

endmodule
`default_nettype wire

>>> rtl/segment_tree_range_sum.sv
// Top level of the segment tree range-sum block with its result register.
//
// Usage: a request on req_* is either a leaf set (req_opcode = 1) or an
// inclusive range-sum query (req_opcode = 0) from req_index to req_right_end.
// A set gives no response; a query gives one response on rsp_range_sum,
// wrapping modulo 2^32, and 0 for an empty range.
// After reset the block sweeps all 2 * LEAVES (2048) node addresses to zero,
// one node per cycle, with req_ready low throughout.
// One request is worked on at a time. A set does one read and one write per
// tree level, from the leaf up to the root, through the memory's read and
// write ports and the shared adder. A query reads one node or steps one
// level per walk step, bounded by the single memory read port.
// The response sits in an output register; a new request is accepted while
// it waits. A stalled rsp_ready holds the response and blocks only the end
// of the next query.
`timescale 1ns / 1ps
`default_nettype none
module segment_tree_range_sum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [stree_pkg::IDX_W-1:0]         req_index,
   input  logic [stree_pkg::IDX_W-1:0]         req_right_end,
   input  logic signed [stree_pkg::DATA_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [stree_pkg::DATA_W-1:0] rsp_range_sum
);
   import stree_pkg::*;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rd_data;
   result_type        result;
   logic              result_ready;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_sum_ff, rsp_sum_in;

   stree_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   stree_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_index     (req_index),
      .req_right_end (req_right_end),
      .req_value     ($unsigned(req_value)),
      .mem_req       (mem_req),
      .rd_data       (rd_data),
      .result        (result),
      .result_ready  (result_ready)
   );

   assign result_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_sum_in   = rsp_sum_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.valid && result_ready) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = result.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_range_sum = $signed(rsp_sum_ff);

endmodule
`default_nettype wire
